/* src/ogtr_pkg.sv */
// shared types, constants and glyph font for the oled glyph text renderer
package ogtr_pkg;

  localparam int unsigned GlyphCount = 13;
  localparam int unsigned GlyphCols  = 12;
  localparam int unsigned GlyphBytes = 2 * GlyphCols;
  localparam int unsigned CmdPerHalf = 5;

  localparam logic [7:0] CHAR_FIRST  = 8'h20;
  localparam logic [7:0] CHAR_LAST   = 8'h7E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] DIGIT_BIAS  = 8'h2F;

  localparam logic [3:0] GLYPH_SPACE = 4'd0;
  localparam logic [3:0] GLYPH_MINUS = 4'd11;
  localparam logic [3:0] GLYPH_DOT   = 4'd12;

  localparam logic [7:0] CMD_ADDR_MODE = 8'h22;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h04;
  localparam logic [3:0] CMD_COL_HIGH  = 4'h1;
  localparam logic [7:0] COL_OFFSET    = 8'h1C;

  localparam logic [7:0] COL_STEP   = 8'd12;
  localparam logic [7:0] WRAP_LIMIT = 8'd60;
  localparam logic [3:0] LINE_PAGES = 4'd3;
  localparam logic [3:0] LAST_PAGE  = 4'd4;

  // slot counter within one half of a run: 5 commands then 12 glyph bytes
  localparam logic [4:0] SLOT_PAGE   = 5'd1;
  localparam logic [4:0] SLOT_ADDR   = 5'd0;
  localparam logic [4:0] SLOT_COLCMD = 5'd2;
  localparam logic [4:0] SLOT_COLLO  = 5'd3;
  localparam logic [4:0] SLOT_COLHI  = 5'd4;
  localparam logic [4:0] SLOT_DATA   = 5'd5;
  localparam logic [4:0] SLOT_LAST   = 5'd16;

  typedef struct packed {
    logic [3:0] glyph;
    logic [3:0] page;
    logic [7:0] col_sum;
  } run_t;

  function automatic logic [191:0] glyph_row(input logic [3:0] g);
    logic [191:0] row;
    case (g)
      4'd1:    row = 192'h00F8FC060606060606FCF800_001F3F6060606060603F1F00;
      4'd2:    row = 192'h000000181CFEFE0000000000_00006060607F7F6060600000;
      4'd3:    row = 192'h00001C0E0606068EFEF80000_00006070787C6E6763600000;
      4'd4:    row = 192'h000C0C8686868686FE7C0000_00303061616161617F3E0000;
      4'd5:    row = 192'h000080E0781E06FEFE000000_000007070606067F7F060000;
      4'd6:    row = 192'h0000FEFEC6C6C6C6C6860000_00006060606060607F3F0000;
      4'd7:    row = 192'h0000FCFE8686868686000000_00003F7F616161617F3F0000;
      4'd8:    row = 192'h0000060686C6E6763E1E0000_000000007F7F000000000000;
      4'd9:    row = 192'h00007CFE86868686FE7C0000_00003E7F616161617F3E0000;
      4'd10:   row = 192'h00007CFE86868686FEFC0000_00006061616161617F3F0000;
      4'd11:   row = 192'h000000808080808080000000_000000010101010101000000;
      4'd12:   row = 192'h000000000000000000000000_000000007070707000000000;
      default: row = '0;
    endcase
    return row;
  endfunction

  // byte b of glyph g, byte 0 is the leftmost column of the top page
  function automatic logic [7:0] glyph_byte(input logic [3:0] g, input logic [4:0] b);
    logic [191:0] row;
    logic [7:0]   pos;
    row = glyph_row(g);
    pos = {3'b000, 5'd23 - b} << 3;
    return row[pos +: 8];
  endfunction

endpackage

/* src/ogtr_emit.sv */
// run sequencer, registered font read and output word register
module ogtr_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            run_valid,
  input  ogtr_pkg::run_t  run,
  output logic            run_done,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_is_data,
  output logic            out_last
);

  logic       half_r, half_nxt;
  logic [4:0] slot_r, slot_nxt;
  logic       valid_r;
  logic       is_data_r;
  logic       last_r;
  logic [7:0] cmd_r;
  logic [7:0] font_q_r;
  logic       adv;
  logic       slot_is_data;
  logic       slot_is_last;
  logic [4:0] font_idx;
  logic [7:0] cmd_byte;

  assign adv          = !valid_r || out_ready;
  assign slot_is_data = slot_r >= ogtr_pkg::SLOT_DATA;
  assign slot_is_last = half_r && (slot_r == ogtr_pkg::SLOT_LAST);
  assign run_done     = adv && run_valid && slot_is_last;

  always_comb begin
    font_idx = '0;
    if (slot_is_data) begin
      font_idx = (half_r ? 5'(ogtr_pkg::GlyphCols) : 5'd0) + (slot_r - ogtr_pkg::SLOT_DATA);
    end
  end

  always_comb begin
    case (slot_r)
      ogtr_pkg::SLOT_ADDR:   cmd_byte = ogtr_pkg::CMD_ADDR_MODE;
      ogtr_pkg::SLOT_PAGE:   cmd_byte = ogtr_pkg::CMD_PAGE_BASE + {4'h0, run.page}
                                        + {7'h00, half_r};
      ogtr_pkg::SLOT_COLCMD: cmd_byte = ogtr_pkg::CMD_COL_LOW;
      ogtr_pkg::SLOT_COLLO:  cmd_byte = {4'h0, run.col_sum[3:0]};
      ogtr_pkg::SLOT_COLHI:  cmd_byte = {ogtr_pkg::CMD_COL_HIGH, run.col_sum[7:4]};
      default:               cmd_byte = 8'h00;
    endcase
  end

  always_comb begin
    half_nxt = half_r;
    slot_nxt = slot_r;
    if (adv && run_valid) begin
      if (slot_r == ogtr_pkg::SLOT_LAST) begin
        slot_nxt = '0;
        half_nxt = !half_r;
      end else begin
        slot_nxt = slot_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= 1'b0;
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      half_r <= half_nxt;
      slot_r <= slot_nxt;
      if (adv) begin
        valid_r <= run_valid;
      end
    end
  end

  // registered font read, lined up with the output word register
  always_ff @(posedge clk) begin
    if (adv && run_valid) begin
      cmd_r     <= cmd_byte;
      is_data_r <= slot_is_data;
      last_r    <= slot_is_last;
      font_q_r  <= ogtr_pkg::glyph_byte(run.glyph, font_idx);
    end
  end

  assign out_valid   = valid_r;
  assign out_byte    = is_data_r ? font_q_r : cmd_r;
  assign out_is_data = is_data_r;
  assign out_last    = last_r;

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && last_r |-> is_data_r)
    else $error("last word of a run is not a data word");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= ogtr_pkg::SLOT_LAST)
    else $error("slot counter out of range");

  a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (slot_r == 5'd0) && !half_r)
    else $error("slot counter not rewound after a run");

  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !run_valid |-> (slot_r == 5'd0) && !half_r)
    else $error("slot counter moved without a run");

endmodule

/* src/oled_glyph_text_renderer.sv */
// top level of the oled page-mode text glyph renderer
// Each printable character gives a run of 34 words (per page: five command words then twelve
// glyph words, top page first), one word per cycle while the receiver keeps out_ready high.
// The cursor is updated when a character is taken, and the next character is taken in the
// cycle its predecessor's last word is issued, so runs follow each other with no gap.
// Characters that give no words (non-printable codes, or any code while halted) are taken
// whenever the pending run slot is free.
module oled_glyph_text_renderer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_new_string,
  input  logic [2:0] in_start_page,
  input  logic [7:0] in_start_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  logic [7:0] col_r, col_nxt;
  logic [3:0] page_r, page_nxt;
  logic [7:0] lsc_r, lsc_nxt;
  logic       halt_r, halt_nxt;
  logic       pend_r, pend_nxt;
  ogtr_pkg::run_t run_r, run_nxt;

  logic       in_fire;
  logic       run_done;
  logic [7:0] eff_col;
  logic [3:0] eff_page;
  logic [7:0] eff_lsc;
  logic       eff_halt;
  logic       printable;
  logic       emit;
  logic [3:0] glyph;
  logic [7:0] col_adv;
  logic       wrap;
  logic [3:0] page_adv;

  assign in_ready = !pend_r || run_done;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    eff_col  = col_r;
    eff_page = page_r;
    eff_lsc  = lsc_r;
    eff_halt = halt_r;
    if (in_new_string) begin
      eff_col  = in_start_column;
      eff_page = {1'b0, in_start_page};
      eff_lsc  = in_start_column;
      eff_halt = 1'b0;
    end
  end

  always_comb begin
    glyph = ogtr_pkg::GLYPH_SPACE;
    if (in_char_code >= ogtr_pkg::CHAR_ZERO && in_char_code <= ogtr_pkg::CHAR_NINE) begin
      glyph = 4'(in_char_code - ogtr_pkg::DIGIT_BIAS);
    end else if (in_char_code == ogtr_pkg::CHAR_MINUS) begin
      glyph = ogtr_pkg::GLYPH_MINUS;
    end else if (in_char_code == ogtr_pkg::CHAR_DOT) begin
      glyph = ogtr_pkg::GLYPH_DOT;
    end
  end

  assign printable = (in_char_code >= ogtr_pkg::CHAR_FIRST) &&
                     (in_char_code <= ogtr_pkg::CHAR_LAST);
  assign emit      = printable && !eff_halt;
  assign col_adv   = eff_col + ogtr_pkg::COL_STEP;
  assign wrap      = col_adv > ogtr_pkg::WRAP_LIMIT;
  assign page_adv  = wrap ? eff_page + ogtr_pkg::LINE_PAGES : eff_page;

  always_comb begin
    col_nxt  = col_r;
    page_nxt = page_r;
    lsc_nxt  = lsc_r;
    halt_nxt = halt_r;
    pend_nxt = pend_r && !run_done;
    run_nxt  = run_r;
    if (in_fire) begin
      col_nxt  = eff_col;
      page_nxt = eff_page;
      lsc_nxt  = eff_lsc;
      halt_nxt = eff_halt;
      if (emit) begin
        col_nxt          = wrap ? eff_lsc : col_adv;
        page_nxt         = page_adv;
        halt_nxt         = page_adv > ogtr_pkg::LAST_PAGE;
        pend_nxt         = 1'b1;
        run_nxt.glyph    = glyph;
        run_nxt.page     = eff_page;
        run_nxt.col_sum  = eff_col + ogtr_pkg::COL_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      page_r <= '0;
      lsc_r  <= '0;
      halt_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      page_r <= page_nxt;
      lsc_r  <= lsc_nxt;
      halt_r <= halt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  ogtr_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .run_valid   (pend_r),
    .run         (run_r),
    .run_done    (run_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

  a_done_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |-> pend_r)
    else $error("run finished with no run pending");

  a_halt_means_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> page_r > ogtr_pkg::LAST_PAGE)
    else $error("halted while cursor page is on screen");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !run_done |-> !in_ready)
    else $error("input taken while a run is still pending");

endmodule

/* test/oled_glyph_text_renderer_tb.sv */
// self-checking testbench for the oled glyph text renderer: directed table then random strings and single characters
module oled_glyph_text_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 245;
  localparam int DIR_COUNT    = 25;
  localparam int TAIL_CYCLES  = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } disp_word_t;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED_RUN, ROW_TYPED_SILENT} row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ns;
    logic [2:0] sp;
    logic [7:0] sc;
    row_kind_t  kind;
    logic [3:0] tpage;
    logic [7:0] tcol;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h30, 1'b0, 3'd0, 8'd0,   ROW_TYPED_RUN,    4'd0, 8'd0},
    '{8'h39, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h2D, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h2E, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h20, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h41, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h1F, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h7F, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h00, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'hFF, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h7E, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h20, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h35, 1'b1, 3'd7, 8'd255, ROW_TYPED_RUN,    4'd7, 8'd255},
    '{8'h31, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h7E, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h33, 1'b1, 3'd0, 8'd0,   ROW_TYPED_RUN,    4'd0, 8'd0},
    '{8'h38, 1'b1, 3'd4, 8'd50,  ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h34, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h0A, 1'b1, 3'd2, 8'd200, ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h36, 1'b0, 3'd0, 8'd0,   ROW_TYPED_RUN,    4'd2, 8'd200},
    '{8'h37, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0},
    '{8'h2E, 1'b1, 3'd3, 8'd250, ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h2D, 1'b0, 3'd0, 8'd0,   ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h32, 1'b1, 3'd5, 8'd60,  ROW_PREDICTED,    4'd0, 8'd0},
    '{8'h30, 1'b0, 3'd0, 8'd0,   ROW_TYPED_SILENT, 4'd0, 8'd0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_new_string = 1'b0;
  logic [2:0] in_start_page = 3'd0;
  logic [7:0] in_start_column = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_last;

  oled_glyph_text_renderer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_new_string  (in_new_string),
    .in_start_page  (in_start_page),
    .in_start_column(in_start_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_data    (out_is_data),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disp_word_t run_words [$];

  logic [7:0] cur_col  = 8'd0;
  logic [3:0] cur_page = 4'd0;
  logic [7:0] line_col = 8'd0;
  logic       halted   = 1'b0;

  int fails         = 0;
  int words_checked = 0;
  int chars_sent    = 0;
  int strings_begun = 0;
  int burst_left    = 0;

  function automatic logic [7:0] font_byte(input logic [3:0] g, input int idx);
    logic [191:0] strip;
    case (g)
      4'd1:    strip = 192'h00F8FC060606060606FCF800_001F3F6060606060603F1F00;
      4'd2:    strip = 192'h000000181CFEFE0000000000_00006060607F7F6060600000;
      4'd3:    strip = 192'h00001C0E0606068EFEF80000_00006070787C6E6763600000;
      4'd4:    strip = 192'h000C0C8686868686FE7C0000_00303061616161617F3E0000;
      4'd5:    strip = 192'h000080E0781E06FEFE000000_000007070606067F7F060000;
      4'd6:    strip = 192'h0000FEFEC6C6C6C6C6860000_00006060606060607F3F0000;
      4'd7:    strip = 192'h0000FCFE8686868686000000_00003F7F616161617F3F0000;
      4'd8:    strip = 192'h0000060686C6E6763E1E0000_000000007F7F000000000000;
      4'd9:    strip = 192'h00007CFE86868686FE7C0000_00003E7F616161617F3E0000;
      4'd10:   strip = 192'h00007CFE86868686FEFC0000_00006061616161617F3F0000;
      4'd11:   strip = 192'h000000808080808080000000_000000010101010101000000;
      4'd12:   strip = 192'h000000000000000000000000_000000007070707000000000;
      default: strip = '0;
    endcase
    return strip[191 - 8 * idx -: 8];
  endfunction

  function automatic logic [3:0] glyph_of(input logic [7:0] ch);
    logic [7:0] d;
    d = ch - ogtr_pkg::DIGIT_BIAS;
    if (ch >= ogtr_pkg::CHAR_ZERO && ch <= ogtr_pkg::CHAR_NINE) return d[3:0];
    if (ch == ogtr_pkg::CHAR_MINUS) return ogtr_pkg::GLYPH_MINUS;
    if (ch == ogtr_pkg::CHAR_DOT) return ogtr_pkg::GLYPH_DOT;
    return ogtr_pkg::GLYPH_SPACE;
  endfunction

  task automatic advance_cursor(input logic [7:0] ch, input logic ns, input logic [2:0] sp,
                                input logic [7:0] sc, output logic emits,
                                output logic [3:0] pg, output logic [7:0] col);
    if (ns) begin
      cur_page = {1'b0, sp};
      cur_col  = sc;
      line_col = sc;
      halted   = 1'b0;
    end
    emits = !halted && ch >= ogtr_pkg::CHAR_FIRST && ch <= ogtr_pkg::CHAR_LAST;
    pg    = cur_page;
    col   = cur_col;
    if (emits) begin
      cur_col = cur_col + ogtr_pkg::COL_STEP;
      if (cur_col > ogtr_pkg::WRAP_LIMIT) begin
        cur_col  = line_col;
        cur_page = cur_page + ogtr_pkg::LINE_PAGES;
      end
      if (cur_page > ogtr_pkg::LAST_PAGE) halted = 1'b1;
    end
  endtask

  task automatic queue_run(input logic [3:0] g, input logic [3:0] pg, input logic [7:0] col);
    logic [7:0] sum;
    sum = col + ogtr_pkg::COL_OFFSET;
    for (int half = 0; half < 2; half++) begin
      run_words.push_back(disp_word_t'{ogtr_pkg::CMD_ADDR_MODE, 1'b0, 1'b0});
      run_words.push_back(disp_word_t'{ogtr_pkg::CMD_PAGE_BASE + {4'h0, pg} + 8'(half),
                                       1'b0, 1'b0});
      run_words.push_back(disp_word_t'{ogtr_pkg::CMD_COL_LOW, 1'b0, 1'b0});
      run_words.push_back(disp_word_t'{{4'h0, sum[3:0]}, 1'b0, 1'b0});
      run_words.push_back(disp_word_t'{{ogtr_pkg::CMD_COL_HIGH, sum[7:4]}, 1'b0, 1'b0});
      for (int i = 0; i < ogtr_pkg::GlyphCols; i++)
        run_words.push_back(disp_word_t'{font_byte(g, half * ogtr_pkg::GlyphCols + i), 1'b1,
                                         (half == 1 && i == ogtr_pkg::GlyphCols - 1)});
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic ns, input logic [2:0] sp,
                           input logic [7:0] sc, output logic emits,
                           output logic [3:0] pg, output logic [7:0] col);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_char_code    <= ch;
    in_new_string   <= ns;
    in_start_page   <= sp;
    in_start_column <= sc;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    advance_cursor(ch, ns, sp, sc, emits, pg, col);
    chars_sent++;
    if (ns) strings_begun++;
  endtask

  task automatic send_predicted(input logic [7:0] ch, input logic ns, input logic [2:0] sp,
                                input logic [7:0] sc);
    logic       emits;
    logic [3:0] pg;
    logic [7:0] col;
    send_char(ch, ns, sp, sc, emits, pg, col);
    if (emits) queue_run(glyph_of(ch), pg, col);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (run_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(ogtr_pkg::CHAR_ZERO, ogtr_pkg::CHAR_NINE));
    if (r < 65) return ogtr_pkg::CHAR_MINUS;
    if (r < 75) return ogtr_pkg::CHAR_DOT;
    if (r < 83) return ogtr_pkg::CHAR_FIRST;
    if (r < 93) return 8'($urandom_range(ogtr_pkg::CHAR_FIRST, ogtr_pkg::CHAR_LAST));
    if (r < 97) return 8'($urandom_range(0, ogtr_pkg::CHAR_FIRST - 1));
    return 8'($urandom_range(ogtr_pkg::CHAR_LAST + 1, 255));
  endfunction

  function automatic logic [7:0] pick_column();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(240, 255));
      2:       return ($urandom_range(0, 1) != 0) ? ogtr_pkg::WRAP_LIMIT : 8'd0;
      default: return 8'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic send_string();
    int         len;
    logic [2:0] sp;
    len = $urandom_range(1, 8);
    sp  = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    send_predicted(pick_char(), 1'b1, sp, pick_column());
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_predicted(pick_char(), 1'b1, 3'($urandom_range(0, 7)), pick_column());
      else
        send_predicted(pick_char(), 1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver stall pattern, chosen by bits 9:8 of a free-running cycle counter
  int rx_cyc = 0;
  always @(negedge clk) begin
    case (rx_cyc[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (rx_cyc[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
    rx_cyc <= rx_cyc + 1;
  end

  always @(posedge clk) begin : word_check
    disp_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (run_words.size() == 0) begin
        $error("unexpected word: out_byte %h out_is_data %b out_last %b",
               out_byte, out_is_data, out_last);
        fails++;
      end else begin
        w = run_words.pop_front();
        words_checked++;
        if (out_byte !== w.value) begin
          $error("out_byte: expected %h, actual %h", w.value, out_byte);
          fails++;
        end
        if (out_is_data !== w.is_data) begin
          $error("out_is_data: expected %b, actual %b", w.is_data, out_is_data);
          fails++;
        end
        if (out_last !== w.last) begin
          $error("out_last: expected %b, actual %b", w.last, out_last);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic       emits;
    logic [3:0] pg;
    logic [7:0] col;
    int         base;
    bit         paused;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_COUNT; r++) begin
      send_char(DIR_ROWS[r].ch, DIR_ROWS[r].ns, DIR_ROWS[r].sp, DIR_ROWS[r].sc, emits, pg, col);
      case (DIR_ROWS[r].kind)
        ROW_PREDICTED:    if (emits) queue_run(glyph_of(DIR_ROWS[r].ch), pg, col);
        ROW_TYPED_RUN:    queue_run(glyph_of(DIR_ROWS[r].ch), DIR_ROWS[r].tpage, DIR_ROWS[r].tcol);
        ROW_TYPED_SILENT: ;
        default:          ;
      endcase
    end

    base = chars_sent;
    while (chars_sent - base < RANDOM_ITEMS) begin
      if (!paused && chars_sent - base >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0)
        send_predicted(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                       3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else
        send_string();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d characters in %0d strings, %0d display words checked",
             chars_sent, strings_begun, words_checked);
    $display("errors found: %0d", fails);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/ogtr_pkg.sv
src/ogtr_emit.sv
src/oled_glyph_text_renderer.sv
test/oled_glyph_text_renderer_tb.sv
